FILE: src/assert_macros.svh
// Assertion macros shared by the spectrum bin level detector RTL.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SBLD_ASSERT_NOW(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Consequent checked at the clock edge after the antecedent.
`define SBLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sbld_pkg.sv
// Package of the spectrum bin level detector: widths, Q15 constants and the
// radix-2 division step shared by the Newton pipeline. No dependencies.
package sbld_pkg;

    localparam int BIN_W        = 6;
    localparam int SAMPLE_W     = 16;
    localparam int MAG_W        = 15;
    localparam int LOG_W        = 5;
    localparam int X_W          = 32;
    localparam int Y_W          = 17;
    localparam int CHUNK        = 4;
    localparam int DIV_STAGES   = X_W / CHUNK;
    localparam int NEWTON_STEPS = 5;
    localparam int LEVEL_DEPTH  = 2 ** BIN_W;
    localparam int FFT_POINTS_DEF = 128;

    localparam logic [MAG_W-1:0] MAG_MAX   = 15'd32767;
    localparam logic [MAG_W-1:0] DECAY_Q15 = 15'd27918;
    localparam logic [MAG_W-1:0] GAIN_Q15  = 15'd4850;
    localparam logic [15:0]      HALF_STEP = 16'd46340;

    typedef struct packed {
        logic [BIN_W-1:0] idx;
        logic             zero;
    } t_side;

    // Restoring division over CHUNK dividend bits. Returns {remainder, quotient bits}.
    function automatic logic [Y_W+CHUNK-1:0] div_chunk(
        input logic [Y_W-1:0]   rem,
        input logic [CHUNK-1:0] xb,
        input logic [Y_W-1:0]   y
    );
        logic [Y_W:0]     r;
        logic [CHUNK-1:0] q;
        r = {1'b0, rem};
        q = '0;
        for (int i = CHUNK - 1; i >= 0; i--) begin
            r = {r[Y_W-1:0], xb[i]};
            if (r >= {1'b0, y}) begin
                r    = r - {1'b0, y};
                q[i] = 1'b1;
            end
        end
        return {r[Y_W-1:0], q};
    endfunction

endpackage

FILE: src/sbld_newton.sv
// One truncating Newton step y' = (x / y + y) / 2 as a pipeline of division
// stages and a final averaging stage. Depends on sbld_pkg.
module sbld_newton (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [sbld_pkg::X_W-1:0]    i_x,
    input  logic [sbld_pkg::Y_W-1:0]    i_y,
    input  sbld_pkg::t_side             i_side,
    output logic                        o_valid,
    output logic [sbld_pkg::X_W-1:0]    o_x,
    output logic [sbld_pkg::Y_W-1:0]    o_y,
    output sbld_pkg::t_side             o_side
);
    localparam int NS = sbld_pkg::DIV_STAGES;
    localparam int XW = sbld_pkg::X_W;
    localparam int YW = sbld_pkg::Y_W;
    localparam int CW = sbld_pkg::CHUNK;

    logic [NS-1:0]   r_v;
    logic [XW-1:0]   r_x   [NS];
    logic [YW-1:0]   r_y   [NS];
    logic [YW-1:0]   r_rem [NS];
    logic [XW-1:0]   r_q   [NS];
    sbld_pkg::t_side r_side[NS];

    logic            r_fv;
    logic [XW-1:0]   r_fx;
    logic [YW-1:0]   r_fy;
    sbld_pkg::t_side r_fside;
    logic [XW:0]     sum;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic            v_in;
        logic [XW-1:0]   x_in;
        logic [YW-1:0]   y_in;
        logic [YW-1:0]   rem_in;
        logic [XW-1:0]   q_in;
        sbld_pkg::t_side side_in;
        logic [YW+CW-1:0] res;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign x_in    = i_x;
            assign y_in    = i_y;
            assign rem_in  = '0;
            assign q_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign x_in    = r_x[k-1];
            assign y_in    = r_y[k-1];
            assign rem_in  = r_rem[k-1];
            assign q_in    = r_q[k-1];
            assign side_in = r_side[k-1];
        end

        assign res = sbld_pkg::div_chunk(rem_in, x_in[XW-1-CW*k -: CW], y_in);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= x_in;
                r_y[k]    <= y_in;
                r_side[k] <= side_in;
                r_rem[k]  <= res[YW+CW-1:CW];
                r_q[k]    <= {q_in[XW-CW-1:0], res[CW-1:0]};
            end
        end
    end

    assign sum = {1'b0, r_q[NS-1]} + {{(XW + 1 - YW){1'b0}}, r_y[NS-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (i_en) begin
            r_fv <= r_v[NS-1];
        end
    end

    // The new estimate never exceeds the first one, which fits in YW bits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fx    <= r_x[NS-1];
            r_fy    <= sum[YW:1];
            r_fside <= r_side[NS-1];
        end
    end

    assign o_valid = r_fv;
    assign o_x     = r_fx;
    assign o_y     = r_fy;
    assign o_side  = r_fside;

endmodule

FILE: src/sbld_level.sv
// Per-bin level store and the peak-hold / averaging update, with forwarding
// of the level written in the same cycle as a read. Depends on sbld_pkg.
module sbld_level #(
    parameter int FFT_POINTS = sbld_pkg::FFT_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_mode,
    input  logic                          i_valid,
    input  logic [sbld_pkg::BIN_W-1:0]    i_idx,
    input  logic [sbld_pkg::MAG_W-1:0]    i_mag,
    output logic                          o_valid,
    output logic [sbld_pkg::BIN_W-1:0]    o_idx,
    output logic [sbld_pkg::MAG_W-1:0]    o_mag,
    output logic [sbld_pkg::MAG_W-1:0]    o_lvl
);
    localparam int STORED_BINS = FFT_POINTS / 2;
    localparam int DEPTH       = sbld_pkg::LEVEL_DEPTH;
    localparam int BW          = sbld_pkg::BIN_W;
    localparam int MW          = sbld_pkg::MAG_W;

    logic [MW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;

    logic          r_a_v;
    logic [BW-1:0] r_a_idx;
    logic [MW-1:0] r_a_mag;
    logic [MW-1:0] r_rd;
    logic          r_rd_ok;
    logic          r_fwd;
    logic [MW-1:0] r_fwd_lvl;

    logic          r_b_v;
    logic [BW-1:0] r_b_idx;
    logic [MW-1:0] r_b_mag;
    logic [MW-1:0] r_b_lvl;

    logic              stored_a;
    logic              wr;
    logic [MW-1:0]     old;
    logic [2*MW-1:0]   prod_o;
    logic [2*MW-1:0]   prod_m;
    logic [2*MW:0]     sum_avg;
    logic [MW-1:0]     lvl_peak;
    logic [MW-1:0]     lvl_new;

    assign stored_a = int'(r_a_idx) < STORED_BINS;
    assign wr       = i_en && r_a_v && stored_a;

    always_comb begin
        if (!stored_a) begin
            old = '0;
        end else if (r_fwd) begin
            old = r_fwd_lvl;
        end else if (r_rd_ok) begin
            old = r_rd;
        end else begin
            old = '0;
        end
    end

    assign prod_o   = {{MW{1'b0}}, old} * {{MW{1'b0}}, sbld_pkg::DECAY_Q15};
    assign prod_m   = {{MW{1'b0}}, r_a_mag} * {{MW{1'b0}}, sbld_pkg::GAIN_Q15};
    assign sum_avg  = {1'b0, prod_o} + {1'b0, prod_m};
    assign lvl_peak = (r_a_mag > old) ? r_a_mag : prod_o[2*MW-1:MW];
    assign lvl_new  = i_mode ? sum_avg[2*MW-1:MW] : lvl_peak;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_a_idx] <= lvl_new;
        end
        if (i_en) begin
            r_rd <= r_mem[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            if (wr) begin
                r_vld[r_a_idx] <= 1'b1;
            end
        end
    end

    // The item leaving the update stage writes at the same edge as this read.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_idx   <= i_idx;
            r_a_mag   <= i_mag;
            r_rd_ok   <= r_vld[i_idx];
            r_fwd     <= r_a_v && stored_a && (r_a_idx == i_idx);
            r_fwd_lvl <= lvl_new;
            r_b_idx   <= r_a_idx;
            r_b_mag   <= r_a_mag;
            r_b_lvl   <= lvl_new;
        end
    end

    assign o_valid = r_b_v;
    assign o_idx   = r_b_idx;
    assign o_mag   = r_b_mag;
    assign o_lvl   = r_b_lvl;

endmodule

FILE: src/spectrum_bin_level_detector.sv
// One FFT bin enters per clock and one result leaves per clock. Squaring, summing
// and seeding take three stages, each of the five Newton steps of the square root
// takes nine (eight four-bit division stages and an averaging stage), the level
// update takes two and the log code one. A request on the output that is not
// taken freezes the whole pipeline, so the input stalls only while a result waits.
// detect_mode must be written only while the pipeline is empty; the block itself
// does not enforce it. Depends on sbld_pkg, sbld_newton, sbld_level and assert_macros.svh.
`include "assert_macros.svh"

module spectrum_bin_level_detector #(
    parameter int FFT_POINTS = sbld_pkg::FFT_POINTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_wr_data,
    input  logic                                i_bin_valid,
    output logic                                o_bin_stall,
    input  logic signed [sbld_pkg::SAMPLE_W-1:0] i_bin_real,
    input  logic signed [sbld_pkg::SAMPLE_W-1:0] i_bin_imag,
    input  logic [sbld_pkg::BIN_W-1:0]          i_bin_index,
    output logic                                o_res_valid,
    input  logic                                i_res_stall,
    output logic [sbld_pkg::BIN_W-1:0]          o_bin_number,
    output logic [sbld_pkg::MAG_W-1:0]          o_magnitude,
    output logic [sbld_pkg::MAG_W-1:0]          o_level,
    output logic [sbld_pkg::LOG_W-1:0]          o_log_level
);
    localparam int XW = sbld_pkg::X_W;
    localparam int YW = sbld_pkg::Y_W;
    localparam int BW = sbld_pkg::BIN_W;
    localparam int MW = sbld_pkg::MAG_W;
    localparam int NSTEP = sbld_pkg::NEWTON_STEPS;

    logic en;
    logic r_mode;

    logic          r_s1_v;
    logic [XW-2:0] r_sq_re;
    logic [XW-2:0] r_sq_im;
    logic [BW-1:0] r_s1_idx;
    logic          r_s2_v;
    logic [XW-1:0] r_pow;
    logic [BW-1:0] r_s2_idx;
    logic          r_s3_v;
    logic [XW-1:0] r_s3_x;
    logic [YW-1:0] r_s3_y;
    sbld_pkg::t_side r_s3_side;

    logic signed [XW-1:0] p_re;
    logic signed [XW-1:0] p_im;
    logic [4:0]    e;
    logic [YW-1:0] seed;

    logic            nw_v    [NSTEP+1];
    logic [XW-1:0]   nw_x    [NSTEP+1];
    logic [YW-1:0]   nw_y    [NSTEP+1];
    sbld_pkg::t_side nw_side [NSTEP+1];

    logic [MW-1:0] mag;
    logic          lv_v;
    logic [BW-1:0] lv_idx;
    logic [MW-1:0] lv_mag;
    logic [MW-1:0] lv_lvl;

    logic [3:0]    m;
    logic [15:0]   norm;
    logic [sbld_pkg::LOG_W-1:0] code;

    logic          r_out_v;
    logic [BW-1:0] r_out_idx;
    logic [MW-1:0] r_out_mag;
    logic [MW-1:0] r_out_lvl;
    logic [sbld_pkg::LOG_W-1:0] r_out_log;

    assign en          = !r_out_v || !i_res_stall;
    assign o_bin_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    assign p_re = i_bin_real * i_bin_real;
    assign p_im = i_bin_imag * i_bin_imag;

    always_comb begin
        e = '0;
        for (int i = 0; i < XW; i++) begin
            if (r_pow[i]) begin
                e = 5'(i);
            end
        end
    end

    assign seed = YW'(1) << e[4:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_s1_v  <= i_bin_valid;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_out_v <= lv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_re        <= p_re[XW-2:0];
            r_sq_im        <= p_im[XW-2:0];
            r_s1_idx       <= i_bin_index;
            r_pow          <= {1'b0, r_sq_re} + {1'b0, r_sq_im};
            r_s2_idx       <= r_s1_idx;
            r_s3_x         <= r_pow;
            r_s3_y         <= seed;
            r_s3_side.idx  <= r_s2_idx;
            r_s3_side.zero <= (r_pow == '0);
        end
    end

    assign nw_v[0]    = r_s3_v;
    assign nw_x[0]    = r_s3_x;
    assign nw_y[0]    = r_s3_y;
    assign nw_side[0] = r_s3_side;

    for (genvar s = 0; s < NSTEP; s++) begin : g_newton
        sbld_newton u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (nw_v[s]),
            .i_x     (nw_x[s]),
            .i_y     (nw_y[s]),
            .i_side  (nw_side[s]),
            .o_valid (nw_v[s+1]),
            .o_x     (nw_x[s+1]),
            .o_y     (nw_y[s+1]),
            .o_side  (nw_side[s+1])
        );
    end

    // A zero power divides by zero on the way; its root is forced to zero here.
    always_comb begin
        if (nw_side[NSTEP].zero) begin
            mag = '0;
        end else if (nw_y[NSTEP] > YW'(sbld_pkg::MAG_MAX)) begin
            mag = sbld_pkg::MAG_MAX;
        end else begin
            mag = nw_y[NSTEP][MW-1:0];
        end
    end

    sbld_level #(
        .FFT_POINTS (FFT_POINTS)
    ) u_level (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_mode  (r_mode),
        .i_valid (nw_v[NSTEP]),
        .i_idx   (nw_side[NSTEP].idx),
        .i_mag   (mag),
        .o_valid (lv_v),
        .o_idx   (lv_idx),
        .o_mag   (lv_mag),
        .o_lvl   (lv_lvl)
    );

    always_comb begin
        m = '0;
        for (int i = 0; i < MW; i++) begin
            if (lv_lvl[i]) begin
                m = 4'(i);
            end
        end
    end

    assign norm = {1'b0, lv_lvl} << (4'd15 - m);
    assign code = {m, (norm > sbld_pkg::HALF_STEP)};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_idx <= lv_idx;
            r_out_mag <= lv_mag;
            r_out_lvl <= lv_lvl;
            r_out_log <= code;
        end
    end

    assign o_res_valid  = r_out_v;
    assign o_bin_number = r_out_idx;
    assign o_magnitude  = r_out_mag;
    assign o_level      = r_out_lvl;
    assign o_log_level  = r_out_log;

    `SBLD_ASSERT_NOW(a_stall_only_when_full, !o_res_valid |-> !o_bin_stall, "input stalled with empty output")
    `SBLD_ASSERT_NOW(a_log_matches_level, (o_res_valid && o_level != '0) |-> ((o_level >> o_log_level[4:1]) == 15'd1), "log code does not match level")
    `SBLD_ASSERT_NEXT(a_mode_written, i_cfg_wr_en, r_mode == $past(i_cfg_wr_data), "detect mode not written")

endmodule

FILE: test/spectrum_bin_level_detector_tb.sv
// Self-checking testbench of the spectrum bin level detector: directed table, then
// random bins with random gaps and stalls, each result checked against a predictor.
// Depends on sbld_pkg and the spectrum_bin_level_detector RTL.
module spectrum_bin_level_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sbld_pkg::*;

    localparam int HALF_BINS = FFT_POINTS_DEF / 2;
    localparam int LATENCY   = 60;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic {MODE_PEAK = 1'b0, MODE_AVERAGE = 1'b1} t_mode;

    typedef struct {
        logic [BIN_W-1:0] bin;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] lvl;
        logic [LOG_W-1:0] lcode;
    } t_level_result;

    typedef struct {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic [BIN_W-1:0]           bin;
        bit                         typed;
        logic [MAG_W-1:0]           mag;
        logic [MAG_W-1:0]           lvl;
        logic [LOG_W-1:0]           lcode;
    } t_row;

    logic clk, rst_n, cfg_wr_en, cfg_wr_data;
    logic bin_valid, bin_stall, res_valid, res_stall;
    logic signed [SAMPLE_W-1:0] bin_real, bin_imag;
    logic [BIN_W-1:0] bin_index, bin_number;
    logic [MAG_W-1:0] magnitude, level;
    logic [LOG_W-1:0] log_level;

    spectrum_bin_level_detector i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_bin_valid(bin_valid), .o_bin_stall(bin_stall),
        .i_bin_real(bin_real), .i_bin_imag(bin_imag), .i_bin_index(bin_index),
        .o_res_valid(res_valid), .i_res_stall(res_stall),
        .o_bin_number(bin_number), .o_magnitude(magnitude),
        .o_level(level), .o_log_level(log_level)
    );

    logic [MAG_W-1:0] level_store [HALF_BINS];
    t_mode            mode_now;
    t_level_result    pending_levels [$];
    int               fail_count = 0;
    int               cycle_count = 0;
    bit               hold_off = 1'b0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [MAG_W-1:0] isqrt_sat(input logic [31:0] x);
        int unsigned e, y;
        if (x == 0) return '0;
        e = 31;
        while (e > 0 && x[e] == 1'b0) e--;
        y = 1 << (e >> 1);
        for (int k = 0; k < NEWTON_STEPS; k++) y = (x / y + y) / 2;
        return (y > MAG_MAX) ? MAG_MAX : y[MAG_W-1:0];
    endfunction

    function automatic logic [LOG_W-1:0] coarse_log(input logic [MAG_W-1:0] v);
        logic [15:0] s;
        int unsigned m;
        s = {1'b0, v};
        m = 15;
        while (m > 0 && !s[15]) begin
            s = s << 1;
            m--;
        end
        m = m << 1;
        if (s > HALF_STEP) m++;
        return m[LOG_W-1:0];
    endfunction

    // Advances the per-bin levels and returns what the block must report.
    function automatic t_level_result update_level(input logic signed [SAMPLE_W-1:0] re,
            input logic signed [SAMPLE_W-1:0] im, input logic [BIN_W-1:0] bin);
        t_level_result r;
        logic [31:0] power;
        logic [31:0] old, nl;
        bit stored;
        power  = 32'(int'(re) * int'(re)) + 32'(int'(im) * int'(im));
        stored = bin < HALF_BINS;
        old    = stored ? 32'(level_store[bin]) : 32'd0;
        r.bin  = bin;
        r.mag  = isqrt_sat(power);
        if (mode_now == MODE_PEAK)
            nl = (r.mag > old) ? 32'(r.mag) : (old * DECAY_Q15) >> 15;
        else
            nl = (old * DECAY_Q15 + 32'(r.mag) * GAIN_Q15) >> 15;
        r.lvl = nl[MAG_W-1:0];
        r.lcode = coarse_log(r.lvl);
        if (stored) level_store[bin] = r.lvl;
        return r;
    endfunction

    task automatic send_bin(input logic signed [SAMPLE_W-1:0] re,
            input logic signed [SAMPLE_W-1:0] im, input logic [BIN_W-1:0] bin);
        bin_real  <= re;
        bin_imag  <= im;
        bin_index <= bin;
        bin_valid <= 1'b1;
        do @(posedge clk); while (bin_stall);
        pending_levels.push_back(update_level(re, im, bin));
        @(negedge clk);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        if (n > 0) begin
            bin_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic drain();
        bin_valid <= 1'b0;
        while (pending_levels.size() > 0) @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic write_mode(input t_mode m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        mode_now  = m;
    endtask

    task automatic random_bin(input bit burst);
        logic signed [SAMPLE_W-1:0] re, im;
        case ($urandom_range(0, 5))
            0: begin re = 16'sh8000; im = 16'sh8000; end
            1: begin re = $urandom_range(0, 15) - 8; im = $urandom_range(0, 15) - 8; end
            2: begin re = $urandom_range(0, 511) - 256; im = $urandom_range(0, 511) - 256; end
            default: begin re = $urandom; im = $urandom; end
        endcase
        // Revisiting few bins keeps the stored levels busy.
        send_bin(re, im, ($urandom_range(0, 3) == 0) ? BIN_W'($urandom) :
                 BIN_W'($urandom_range(0, 7)));
        if (!burst) idle_gap();
    endtask

    // Receiver stalls, with one long hold-off.
    always @(negedge clk) begin
        if (!rst_n || hold_off) res_stall <= hold_off;
        else if ($urandom_range(0, 19) == 0) res_stall <= 1'b1;
        else res_stall <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk) begin
        t_level_result exp_r;
        if (rst_n && res_valid && !res_stall) begin
            if (pending_levels.size() == 0) begin
                $display("%0t: result with none expected: bin %0d", $time, bin_number);
                fail_count++;
            end else begin
                exp_r = pending_levels.pop_front();
                if (bin_number !== exp_r.bin || magnitude !== exp_r.mag ||
                    level !== exp_r.lvl || log_level !== exp_r.lcode) begin
                    $display("%0t: expected bin %0d mag %0d level %0d log %0d, got %0d %0d %0d %0d",
                             $time, exp_r.bin, exp_r.mag, exp_r.lvl, exp_r.lcode,
                             bin_number, magnitude, level, log_level);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_row rows [$];
        t_level_result got;
        rst_n = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = 1'b0; bin_valid = 1'b0;
        bin_real = '0; bin_imag = '0; bin_index = '0; res_stall = 1'b0;
        for (int i = 0; i < HALF_BINS; i++) level_store[i] = '0;
        mode_now = MODE_PEAK;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Typed rows: zero power, the largest power, a level reaching the top code and a small exact root.
        rows = '{
            '{16'sd0, 16'sd0, 6'd0, 1, 15'd0, 15'd0, 5'd0},
            '{-16'sd32768, -16'sd32768, 6'd1, 1, 15'd32767, 15'd32767, 5'd29},
            '{16'sd32767, 16'sd0, 6'd2, 1, 15'd32767, 15'd32767, 5'd29},
            '{16'sd3, 16'sd4, 6'd3, 1, 15'd5, 15'd5, 5'd4},
            '{16'sd0, -16'sd32768, 6'd63, 1, 15'd32767, 15'd32767, 5'd29},
            '{16'sd1, 16'sd0, 6'd1, 0, 0, 0, 0},
            '{16'sd0, 16'sd0, 6'd3, 0, 0, 0, 0},
            '{16'sd100, -16'sd100, 6'd40, 0, 0, 0, 0},
            '{-16'sd1, -16'sd1, 6'd32, 0, 0, 0, 0},
            '{16'sh5555, 16'shAAAA, 6'd21, 0, 0, 0, 0},
            '{16'shAAAA, 16'sh5555, 6'd42, 0, 0, 0, 0}
        };
        foreach (rows[i]) begin
            send_bin(rows[i].re, rows[i].im, rows[i].bin);
            if (rows[i].typed) begin
                got = pending_levels[$];
                if (got.mag !== rows[i].mag || got.lvl !== rows[i].lvl ||
                    got.lcode !== rows[i].lcode) begin
                    $display("%0t: table row %0d expected %0d %0d %0d, predicted %0d %0d %0d",
                             $time, i, rows[i].mag, rows[i].lvl, rows[i].lcode,
                             got.mag, got.lvl, got.lcode);
                    fail_count++;
                end
            end
        end
        drain();
        write_mode(MODE_AVERAGE);
        foreach (rows[i]) send_bin(rows[i].re, rows[i].im, rows[i].bin);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            write_mode(t_mode'(phase[0]));
            if (phase == 1) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (150) @(negedge clk);
                        hold_off = 1'b0;
                    end
                    for (int k = 0; k < 90; k++) random_bin(1'b1);
                join
            end
            for (int k = 0; k < 120; k++) begin
                random_bin(k[4]);
                if (k == 60) drain();
            end
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
